>>> rtl/brme_pkg.sv
// Shared types, codes and decode helpers for the byte register machine executor.
// No dependencies; imported by the top level and by its checker.
`default_nettype none

package brme_pkg;

    // Default depth of the program store
    localparam int PROG_DEPTH_DEF = 256;
    // Data memory and label table are fixed at one entry per byte value
    localparam int DATA_DEPTH     = 256;
    localparam int LABEL_DEPTH    = 256;
    localparam int NUM_REGS       = 5;

    typedef logic [2:0] t_reg_idx;
    typedef logic [8:0] t_pc;

    // Item opcodes
    localparam logic [1:0] OPC_LOAD    = 2'd0;
    localparam logic [1:0] OPC_STEP    = 2'd1;
    localparam logic [1:0] OPC_RESTART = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_END       = 2'd1;
    localparam logic [1:0] ST_LABEL_ERR = 2'd2;

    // Machine operations (low nibble of the operation byte)
    localparam logic [3:0] OP_ADD   = 4'h1;
    localparam logic [3:0] OP_SUB   = 4'h2;
    localparam logic [3:0] OP_LOAD  = 4'h3;
    localparam logic [3:0] OP_STM   = 4'h4;
    localparam logic [3:0] OP_XOR   = 4'h5;
    localparam logic [3:0] OP_AND   = 4'h6;
    localparam logic [3:0] OP_OR    = 4'h7;
    localparam logic [3:0] OP_NOT   = 4'h8;
    localparam logic [3:0] OP_CMP   = 4'h9;
    localparam logic [3:0] OP_JMP   = 4'hA;
    localparam logic [3:0] OP_JEQ   = 4'hB;
    localparam logic [3:0] OP_MOV   = 4'hC;
    localparam logic [3:0] OP_PUTC  = 4'hD;

    localparam logic [7:0] LABEL_BYTE = 8'hFF;

    // Register field of the operation byte: 1..5 select A..E, anything else A
    function automatic t_reg_idx reg_of_field(input logic [2:0] fld);
        t_reg_idx idx;
        if (fld >= 3'd1 && fld <= 3'd5) begin
            idx = fld - 3'd1;
        end else begin
            idx = 3'd0;
        end
        return idx;
    endfunction

    // Register code in an argument byte: 0x10..0x50 in steps of 0x10, else A
    function automatic t_reg_idx reg_of_arg(input logic [7:0] code);
        t_reg_idx idx;
        if (!code[7] && code[3:0] == 4'h0 && code[6:4] >= 3'd1 && code[6:4] <= 3'd5) begin
            idx = code[6:4] - 3'd1;
        end else begin
            idx = 3'd0;
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> rtl/byte_register_machine_executor.sv
// Byte register machine executor: program store, label table, register file and
// data memory, each a synchronous memory, driven by a small step sequencer. Uses brme_pkg.
// Load, restart and halted or ended steps answer straight from idle without busy; label
// words from fetch; other steps via operand read and execute, data loads via write-back.
// Other steps hold busy until the result; the next item may be taken in the result cycle.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Synchronous active-low reset clears control state, flags, the length register and
// the valid bits of labels, registers and data; the program store stays undefined.
`default_nettype none

module byte_register_machine_executor
    import brme_pkg::*;
#(
    parameter int PROGRAM_DEPTH = PROG_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // command channel
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_word_index,
    input  wire logic [7:0] i_op_byte,
    input  wire logic [7:0] i_arg_byte,
    // configuration write channel: program length
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [8:0] i_cfg_data,
    // result word
    output logic            o_result_valid,
    output logic            o_print_valid,
    output logic [7:0]      o_print_char,
    output logic [8:0]      o_next_pc,
    output logic [1:0]      o_status
);

    localparam int AW = $clog2(PROGRAM_DEPTH);
    // Length is also capped by the 256-word label/pc space
    localparam t_pc LEN_CAP = t_pc'((PROGRAM_DEPTH < 256) ? PROGRAM_DEPTH : 256);

    // Sequencer states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_FETCH   = 2'd1;
    localparam logic [1:0] S_EXEC    = 2'd2;
    localparam logic [1:0] S_LOAD_WB = 2'd3;

    // ---------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------
    logic [1:0] r_state, n_state;
    t_pc        r_pc, n_pc;
    logic [1:0] r_halt, n_halt;
    logic       r_eq, n_eq;
    t_pc        r_len;

    // decoded fields of the word under execution
    logic [3:0] r_op;
    logic       r_imm;
    logic [7:0] r_arg;
    t_reg_idx   r_r1;

    // result word
    logic       r_out_valid, n_out_valid;
    logic       r_pv, n_pv;
    logic [7:0] r_pch, n_pch;
    t_pc        r_out_pc;
    logic [1:0] r_out_st;

    logic accept;
    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // Program store: undefined until written, one write and one read port
    // ---------------------------------------------------------------------
    logic [15:0] prog_mem [PROGRAM_DEPTH];
    logic [15:0] r_prog_rd;
    logic        prog_we;
    logic        load_in_range;

    assign load_in_range = (32'(i_word_index) < PROGRAM_DEPTH);

    always_ff @(posedge i_clk) begin
        if (prog_we) begin
            prog_mem[AW'(i_word_index)] <= {i_op_byte, i_arg_byte};
        end
        r_prog_rd <= prog_mem[AW'(r_pc)];
    end

    // fields of the fetched word
    logic [7:0] f_opb, f_arg;
    assign f_opb = r_prog_rd[15:8];
    assign f_arg = r_prog_rd[7:0];

    // ---------------------------------------------------------------------
    // Label table: word position per label number, valid bits in flops
    // ---------------------------------------------------------------------
    logic [7:0]             lbl_mem [LABEL_DEPTH];
    logic [LABEL_DEPTH-1:0] r_lbl_valid;
    logic [7:0]             r_lbl_rd;
    logic                   r_lbl_vld;
    logic                   lbl_we;

    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            lbl_mem[i_arg_byte] <= i_word_index;
        end
        r_lbl_rd <= lbl_mem[f_arg];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lbl_valid <= '0;
            r_lbl_vld   <= 1'b0;
        end else begin
            if (lbl_we) begin
                r_lbl_valid[i_arg_byte] <= 1'b1;
            end
            r_lbl_vld <= r_lbl_valid[f_arg];
        end
    end

    // ---------------------------------------------------------------------
    // Register file: two read ports, one write port; an entry not yet
    // written since restart reads as zero
    // ---------------------------------------------------------------------
    logic [7:0]          rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_rf_valid;
    logic [7:0]          r_rd1, r_rd2;
    logic                rf_we;
    logic [7:0]          rf_wd;
    t_reg_idx            rf_ra1, rf_ra2;
    logic                clr_machine;

    assign rf_ra1 = reg_of_field(f_opb[6:4]);
    assign rf_ra2 = reg_of_arg(f_arg);

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf_mem[r_r1] <= rf_wd;
        end
        r_rd1 <= r_rf_valid[rf_ra1] ? rf_mem[rf_ra1] : 8'h00;
        r_rd2 <= r_rf_valid[rf_ra2] ? rf_mem[rf_ra2] : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid <= '0;
        end else if (clr_machine) begin
            r_rf_valid <= '0;
        end else if (rf_we) begin
            r_rf_valid[r_r1] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Data memory: one port, read data registered; unwritten bytes read zero
    // ---------------------------------------------------------------------
    logic [7:0]            dm_mem [DATA_DEPTH];
    logic [DATA_DEPTH-1:0] r_dm_valid;
    logic [7:0]            r_dm_rd;
    logic                  dm_we;
    logic [7:0]            dm_addr;

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            dm_mem[dm_addr] <= r_rd1;
        end
        r_dm_rd <= r_dm_valid[dm_addr] ? dm_mem[dm_addr] : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dm_valid <= '0;
        end else if (clr_machine) begin
            r_dm_valid <= '0;
        end else if (dm_we) begin
            r_dm_valid[dm_addr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Execute datapath
    // ---------------------------------------------------------------------
    logic [7:0] dst, src;
    t_pc        eff_len;
    logic       jump;

    assign dst     = r_rd1;
    assign src     = r_imm ? r_arg : r_rd2;
    assign eff_len = (r_len > LEN_CAP) ? LEN_CAP : r_len;

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_halt      = r_halt;
        n_eq        = r_eq;
        n_out_valid = 1'b0;
        n_pv        = 1'b0;
        n_pch       = 8'h00;
        prog_we     = 1'b0;
        lbl_we      = 1'b0;
        rf_we       = 1'b0;
        rf_wd       = 8'h00;
        dm_we       = 1'b0;
        dm_addr     = src;
        clr_machine = 1'b0;
        jump        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OPC_LOAD: begin
                            prog_we     = load_in_range;
                            lbl_we      = load_in_range && (i_op_byte == LABEL_BYTE);
                            n_out_valid = 1'b1;
                        end
                        OPC_STEP: begin
                            priority if (r_halt != ST_OK) begin
                                n_out_valid = 1'b1;
                            end else if (r_pc >= eff_len) begin
                                n_halt      = ST_END;
                                n_out_valid = 1'b1;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                        OPC_RESTART: begin
                            clr_machine = 1'b1;
                            n_pc        = '0;
                            n_halt      = ST_OK;
                            n_eq        = 1'b0;
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                // label words execute as no-ops
                if (f_opb == LABEL_BYTE) begin
                    n_pc        = r_pc + t_pc'(1);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_op)
                    OP_ADD: begin
                        rf_we = 1'b1;
                        rf_wd = dst + src;
                    end
                    OP_SUB: begin
                        rf_we = 1'b1;
                        rf_wd = dst - src;
                    end
                    OP_LOAD: begin
                        n_state = S_LOAD_WB;
                    end
                    OP_STM: begin
                        dm_we = 1'b1;
                    end
                    OP_XOR: begin
                        rf_we = 1'b1;
                        rf_wd = dst ^ src;
                    end
                    OP_AND: begin
                        rf_we = 1'b1;
                        rf_wd = dst & src;
                    end
                    OP_OR: begin
                        rf_we = 1'b1;
                        rf_wd = dst | src;
                    end
                    OP_NOT: begin
                        rf_we = 1'b1;
                        rf_wd = ~dst;
                    end
                    OP_CMP: begin
                        n_eq = (dst == src);
                    end
                    OP_JMP: begin
                        jump = 1'b1;
                    end
                    OP_JEQ: begin
                        jump = r_eq;
                    end
                    OP_MOV: begin
                        rf_we = 1'b1;
                        rf_wd = src;
                    end
                    OP_PUTC: begin
                        n_pv  = 1'b1;
                        n_pch = r_imm ? r_arg : dst;
                    end
                    default: begin
                    end
                endcase

                if (jump) begin
                    if (!r_lbl_vld) begin
                        n_halt = ST_LABEL_ERR;
                    end else begin
                        n_pc = {1'b0, r_lbl_rd} + t_pc'(1);
                    end
                end else begin
                    n_pc = r_pc + t_pc'(1);
                end
                n_out_valid = (r_op != OP_LOAD);
            end
            S_LOAD_WB: begin
                rf_we       = 1'b1;
                rf_wd       = r_dm_rd;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_halt      <= ST_OK;
            r_eq        <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_halt      <= n_halt;
            r_eq        <= n_eq;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_len <= i_cfg_data;
            end
        end
    end

    // word fields latched at fetch; result payload latched with its strobe
    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_op  <= f_opb[3:0];
            r_imm <= f_opb[7];
            r_arg <= f_arg;
            r_r1  <= rf_ra1;
        end
        if (n_out_valid) begin
            r_pv     <= n_pv;
            r_pch    <= n_pch;
            r_out_pc <= n_pc;
            r_out_st <= n_halt;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_print_valid  = r_pv;
    assign o_print_char   = r_pch;
    assign o_next_pc      = r_out_pc;
    assign o_status       = r_out_st;

endmodule

`default_nettype wire

>>> rtl/brme_checker.sv
// Port-level checker for byte_register_machine_executor, attached by bind.
// Depends on brme_pkg for status codes.
`default_nettype none

module brme_checker
    import brme_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_result_valid,
    input wire logic       o_print_valid,
    input wire logic [8:0] o_next_pc,
    input wire logic [1:0] o_status
);

    // an accepted word either answers at once or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_result_valid || busy)
        else $error("accepted word neither answered nor busy");

    // busy ends only with a result word
    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_result_valid)
        else $error("busy dropped without a result");

    // printing only happens on a step that completed normally
    a_print_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_print_valid |-> o_status == ST_OK)
        else $error("print with non-ok status");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_next_pc <= 9'd256 && o_status != 2'd3)
        else $error("result pc or status out of range");

endmodule

bind byte_register_machine_executor brme_checker u_brme_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_print_valid  (o_print_valid),
    .o_next_pc      (o_next_pc),
    .o_status       (o_status)
);

`default_nettype wire

>>> bench/brme_checker.sv
// Scoreboard for the byte register machine executor: watches the command, length and result
// channels, keeps its own copy of the machine state and compares every result word.
// Depends on brme_pkg for codes and widths.
module brme_scoreboard
    import brme_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_word_index,
    input  logic [7:0] i_op_byte,
    input  logic [7:0] i_arg_byte,
    input  logic       i_cfg_valid,
    input  logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data,
    input  logic       o_result_valid,
    input  logic       o_print_valid,
    input  logic [7:0] o_print_char,
    input  logic [8:0] o_next_pc,
    input  logic [1:0] o_status,
    output int         n_errors,
    output int         n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic       printed;
        logic [7:0] char_out;
        t_pc        pc_after;
        logic [1:0] status;
    } t_result;

    // mirrored machine state
    logic [15:0] prog_mem  [PROG_DEPTH_DEF];
    t_pc         label_pos [LABEL_DEPTH];
    logic        label_ok  [LABEL_DEPTH];
    logic [7:0]  regs      [NUM_REGS];
    logic [7:0]  dmem      [DATA_DEPTH];
    t_pc         pc;
    logic        eq_flag;
    logic [1:0]  halt_code;
    logic [8:0]  prog_len;

    t_result due_results [$];

    // register field 1..5 is A..E, anything else falls back to A
    function automatic int field_reg(input logic [2:0] f);
        return (f >= 3'd1 && f <= 3'd5) ? int'(f) - 1 : 0;
    endfunction

    // argument register codes are 0x10..0x50 exactly
    function automatic int arg_reg(input logic [7:0] code);
        return (code[3:0] == 4'h0 && code >= 8'h10 && code <= 8'h50) ? int'(code[7:4]) - 1 : 0;
    endfunction

    task automatic clear_machine();
        for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
        for (int i = 0; i < DATA_DEPTH; i++) dmem[i] = '0;
        pc        = '0;
        eq_flag   = 1'b0;
        halt_code = ST_OK;
    endtask

    task automatic flag(input string msg);
        n_errors++;
        if (n_errors <= REPORT_LIMIT) $display("%0t ERROR: %s", $time, msg);
    endtask

    // one step of the machine
    task automatic execute_word(output logic printed, output logic [7:0] shown);
        logic [7:0] ob;
        logic [7:0] ab;
        logic [7:0] src;
        logic       take;
        int         rd;
        int         rs;
        int         eff;
        printed = 1'b0;
        shown   = '0;
        take    = 1'b0;
        eff     = (prog_len > PROG_DEPTH_DEF) ? PROG_DEPTH_DEF : int'(prog_len);
        if (halt_code != ST_OK) return;
        if (int'(pc) >= eff) begin
            halt_code = ST_END;
            return;
        end
        {ob, ab} = prog_mem[pc[7:0]];
        if (ob == LABEL_BYTE) begin
            pc = pc + 1'b1;
            return;
        end
        rd  = field_reg(ob[6:4]);
        rs  = arg_reg(ab);
        src = ob[7] ? ab : regs[rs];
        case (ob[3:0])
            OP_ADD:   regs[rd] = regs[rd] + src;
            OP_SUB:   regs[rd] = regs[rd] - src;
            OP_LOAD:  regs[rd] = dmem[src];
            OP_STM:   dmem[src] = regs[rd];
            OP_XOR:   regs[rd] = regs[rd] ^ src;
            OP_AND:   regs[rd] = regs[rd] & src;
            OP_OR:    regs[rd] = regs[rd] | src;
            OP_NOT:   regs[rd] = ~regs[rd];
            OP_CMP:   eq_flag = (regs[rd] == src);
            OP_JMP:   take = 1'b1;
            OP_JEQ:   take = eq_flag;
            OP_MOV:   regs[rd] = src;
            OP_PUTC: begin
                printed = 1'b1;
                shown   = ob[7] ? ab : regs[rd];
            end
            default: ;
        endcase
        // an undefined label halts and leaves the counter where it was
        if (!take) pc = pc + 1'b1;
        else if (label_ok[ab]) pc = label_pos[ab] + 1'b1;
        else halt_code = ST_LABEL_ERR;
    endtask

    task automatic execute_command(input logic [1:0] opc, input logic [7:0] idx,
                                   input logic [7:0] ob, input logic [7:0] ab,
                                   output t_result res);
        res = '0;
        case (opc)
            OPC_LOAD: begin
                prog_mem[idx] = {ob, ab};
                if (ob == LABEL_BYTE) begin
                    label_pos[ab] = {1'b0, idx};
                    label_ok[ab]  = 1'b1;
                end
            end
            OPC_STEP:    execute_word(res.printed, res.char_out);
            OPC_RESTART: clear_machine();
            default: ;
        endcase
        res.pc_after = pc;
        res.status   = halt_code;
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < LABEL_DEPTH; i++) label_ok[i] = 1'b0;
            clear_machine();
            prog_len = '0;
            due_results.delete();
        end else begin
            // result first: it always belongs to an older command word
            if (o_result_valid) begin
                got = '{o_print_valid, o_print_char, o_next_pc, o_status};
                if (due_results.size() == 0) begin
                    flag($sformatf("unexpected result word pv=%0b ch=%02h pc=%0d st=%0d",
                                   got.printed, got.char_out, got.pc_after, got.status));
                end else begin
                    want = due_results.pop_front();
                    if (got.printed !== want.printed || got.char_out !== want.char_out ||
                        got.pc_after !== want.pc_after || got.status !== want.status) begin
                        flag($sformatf({"result mismatch: expected pv=%0b ch=%02h pc=%0d st=%0d,",
                                        " got pv=%0b ch=%02h pc=%0d st=%0d"},
                                       want.printed, want.char_out, want.pc_after, want.status,
                                       got.printed, got.char_out, got.pc_after, got.status));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) prog_len = i_cfg_data;
            if (start && !busy) begin
                execute_command(i_opcode, i_word_index, i_op_byte, i_arg_byte, want);
                due_results.push_back(want);
            end
        end
        n_pending = due_results.size();
    end

endmodule

>>> bench/tb_top.sv
// Testbench top for the byte register machine executor: clock, reset, command and length
// stimulus, watchdog and verdict. Depends on brme_pkg, brme_scoreboard and the block itself.
module tb_top;
    import brme_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 1500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    // opcode 3 is spare: the block answers it without doing anything
    localparam logic [1:0] OPC_SPARE = 2'd3;
    // operation 14 is one of the unused ones
    localparam logic [3:0] OP_SPARE  = 4'hE;

    // register field values; 0 and 6 are odd codes that fall back to A
    localparam logic [2:0] R_NONE = 3'd0;
    localparam logic [2:0] R_A    = 3'd1;
    localparam logic [2:0] R_C    = 3'd3;
    localparam logic [2:0] R_D    = 3'd4;
    localparam logic [2:0] R_E    = 3'd5;
    localparam logic [2:0] R_ODD  = 3'd6;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       start          = 1'b0;
    logic       busy;
    logic [1:0] i_opcode       = OPC_LOAD;
    logic [7:0] i_word_index   = '0;
    logic [7:0] i_op_byte      = '0;
    logic [7:0] i_arg_byte     = '0;
    logic       i_cfg_valid    = 1'b0;
    logic       o_cfg_ready;
    logic [8:0] i_cfg_data     = '0;
    logic       o_result_valid;
    logic       o_print_valid;
    logic [7:0] o_print_char;
    logic [8:0] o_next_pc;
    logic [1:0] o_status;

    int n_errors;
    int n_pending;

    // which program words have been written; stepping an unwritten one is never allowed
    bit loaded [256];

    int idle_pct     = 0;
    int quiet_cycles = 0;
    int n_items      = 0;
    int n_loads      = 0;
    int n_steps      = 0;
    int n_restarts   = 0;
    int n_spare      = 0;
    int n_programs   = 0;
    int n_len_writes = 0;

    // 8 ns clock, high then low
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    byte_register_machine_executor u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_word_index   (i_word_index),
        .i_op_byte      (i_op_byte),
        .i_arg_byte     (i_arg_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_print_valid  (o_print_valid),
        .o_print_char   (o_print_char),
        .o_next_pc      (o_next_pc),
        .o_status       (o_status)
    );

    brme_scoreboard u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_word_index   (i_word_index),
        .i_op_byte      (i_op_byte),
        .i_arg_byte     (i_arg_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_print_valid  (o_print_valid),
        .o_print_char   (o_print_char),
        .o_next_pc      (o_next_pc),
        .o_status       (o_status),
        .n_errors       (n_errors),
        .n_pending      (n_pending)
    );

    // Watchdog: any accepted word on any channel resets the count. Reset cycles don't count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles with no word accepted", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [15:0] instr(input logic imm, input logic [2:0] fld,
                                          input logic [3:0] op, input logic [7:0] arg);
        return {imm, fld, op, arg};
    endfunction

    function automatic logic [7:0] rcode(input logic [2:0] r);
        return {1'b0, r, 4'h0};
    endfunction

    // Labels mostly from a small pool, 0 to 9, so jumps usually land. Now and then any byte
    // at all, which keeps the undefined-label halt in play.
    function automatic logic [7:0] pick_label();
        if ($urandom_range(0, 9) < 9) return 8'($urandom_range(0, 9));
        return 8'($urandom);
    endfunction

    // One random program word, weighted towards sensible code
    function automatic logic [15:0] random_instr();
        logic [7:0] ab;
        logic [3:0] op;
        logic [2:0] fld;
        logic       imm;
        int         pick;
        pick = $urandom_range(0, 99);
        imm  = 1'($urandom_range(0, 1));
        fld  = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 5)) : 3'($urandom_range(0, 7));
        ab   = 8'($urandom);
        if (pick < 12) begin
            return {LABEL_BYTE, pick_label()};
        end else if (pick < 24) begin
            return instr(imm, fld, $urandom_range(0, 1) ? OP_JMP : OP_JEQ, pick_label());
        end else if (pick < 30) begin
            // plain noise, every bit free
            return 16'($urandom);
        end
        op = 4'($urandom_range(0, 15));
        if (op == OP_JMP || op == OP_JEQ) op = OP_MOV;
        // small addresses so loads and stores hit the same data bytes
        if (imm && $urandom_range(0, 9) < 7) ab = 8'($urandom_range(0, 15));
        else if (!imm && $urandom_range(0, 9) < 8) ab = rcode(3'($urandom_range(1, 5)));
        return instr(imm, fld, op, ab);
    endfunction

    // Drive one command word at a falling edge and hold it until the block takes it.
    // Returns at the following falling edge with start still high, so back-to-back words
    // never see start dropped and raised in the same time step.
    task automatic send_command(input logic [1:0] opc, input logic [7:0] idx,
                                input logic [15:0] word);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start        <= 1'b1;
        i_opcode     <= opc;
        i_word_index <= idx;
        i_op_byte    <= word[15:8];
        i_arg_byte   <= word[7:0];
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        case (opc)
            OPC_LOAD: begin
                loaded[idx] = 1'b1;
                n_loads++;
            end
            OPC_STEP:    n_steps++;
            OPC_RESTART: n_restarts++;
            default:     n_spare++;
        endcase
        if (opc != OPC_SPARE) n_items++;
    endtask

    task automatic send_random(input logic [1:0] opc);
        send_command(opc, 8'($urandom), 16'($urandom));
    endtask

    // Drop start and wait for every outstanding result word. Every command word yields
    // exactly one result, so once nothing is due the block is idle.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (n_pending != 0 || busy) @(negedge i_clk);
    endtask

    // Fill any unwritten word below the new length, then write the length while idle
    task automatic write_length(input logic [8:0] len);
        int lim;
        lim = (len > 256) ? 256 : int'(len);
        for (int i = 0; i < lim; i++) begin
            if (!loaded[i]) send_command(OPC_LOAD, 8'(i), random_instr());
        end
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_len_writes++;
    endtask

    initial begin
        logic [15:0] demo [12];
        logic [8:0]  prog_len;
        int          eff;
        int          n_new;
        int          n_cmds;
        int          pick;

        // Directed program: wrapping add and subtract, store then load of the top data byte,
        // register-register xor and compare, a taken jeq through a label, print with an odd
        // register field, not, and finally a jump to a label that was never defined.
        demo = '{
            instr(1'b1, R_A,    OP_MOV,   8'hFF),
            instr(1'b1, R_A,    OP_ADD,   8'h01),
            instr(1'b1, R_E,    OP_SUB,   8'h01),
            instr(1'b1, R_E,    OP_STM,   8'hFF),
            instr(1'b1, R_C,    OP_LOAD,  8'hFF),
            instr(1'b0, R_C,    OP_XOR,   rcode(R_E)),
            instr(1'b0, R_C,    OP_CMP,   rcode(R_A)),
            instr(1'b0, R_NONE, OP_JEQ,   8'h07),
            {LABEL_BYTE, 8'h07},
            instr(1'b1, R_ODD,  OP_PUTC,  8'h41),
            instr(1'b0, R_D,    OP_NOT,   8'h00),
            instr(1'b0, R_A,    OP_JMP,   8'h99)
        };

        // Synchronous reset, released on a falling edge
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed part ----
        // Length is 0 after reset: the first step ends the program, the second sees it halted
        send_random(OPC_STEP);
        send_random(OPC_STEP);
        send_random(OPC_RESTART);
        for (int i = 0; i < 12; i++) send_command(OPC_LOAD, 8'(i), demo[i]);
        write_length(9'd12);
        // eleven steps run the program into the undefined label, one more sees the halt
        repeat (12) send_random(OPC_STEP);
        send_random(OPC_SPARE);
        // overwrite the label word with an unused operation: the label entry must survive
        send_command(OPC_LOAD, 8'd8, instr(1'b0, R_NONE, OP_SPARE, 8'h00));
        send_random(OPC_RESTART);
        repeat (10) send_random(OPC_STEP);

        // ---- random programs ----
        // Each round loads a program, sets its length, restarts and runs it with the odd
        // restart, spare word and live patch mixed in. Sender idling rotates per program.
        while (n_items < ITEM_TARGET) begin
            n_programs++;
            case (n_programs % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 57;
                default: idle_pct = 18;
            endcase

            // extremes forced early; beyond 256 the length saturates
            pick = $urandom_range(0, 99);
            if (n_programs == 2 || pick < 4) prog_len = 9'd511;
            else if (n_programs == 4 || pick < 8) prog_len = 9'd0;
            else if (pick < 16) prog_len = 9'd256;
            else if (pick < 30) prog_len = 9'($urandom_range(41, 255));
            else prog_len = 9'($urandom_range(1, 40));
            eff = (prog_len > 256) ? 256 : int'(prog_len);

            // short programs are written whole; long ones get a patch of fresh words
            n_new = (eff <= 40) ? eff : $urandom_range(10, 40);
            for (int k = 0; k < n_new; k++) begin
                send_command(OPC_LOAD, (eff <= 40) ? 8'(k) : 8'($urandom_range(0, eff - 1)),
                             random_instr());
            end
            write_length(prog_len);
            send_random(OPC_RESTART);

            n_cmds = $urandom_range(5, (eff < 24) ? 3 * eff + 10 : 80);
            repeat (n_cmds) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) send_random(OPC_RESTART);
                else if (pick < 5) send_random(OPC_SPARE);
                else if (pick < 10) send_command(OPC_LOAD, 8'($urandom), random_instr());
                else send_random(OPC_STEP);
            end
        end

        // ---- wind down ----
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Run covered %0d loads, %0d steps, %0d restarts and %0d spare words",
                 n_loads, n_steps, n_restarts, n_spare);
        $display("over %0d programs with %0d program length writes, 0 and 511 among them",
                 n_programs, n_len_writes);
        if (n_errors == 0 && n_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
